/* hdl/dsrm_pkg.sv */
`timescale 1ns / 1ps

package dsrm_pkg;

  localparam int CHANNELS_DEF        = 2;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 8;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W    = 3;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_A = 2'd0,
    REG_STEP_B = 2'd1,
    REG_GAIN_A = 2'd2,
    REG_GAIN_B = 2'd3
  } cfg_reg_t;

  // Quarter-wave entry k: sin((k + 1/2) * (pi/2) / 2^stb), Q0.15 magnitude.
  // Evaluated at elaboration only.
  function automatic logic [14:0] rom_entry(input int unsigned k, input int unsigned stb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(2 * k + 1) * PI_Q30) >> (stb + 2);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[14:0];
  endfunction

endpackage

/* hdl/dual_sine_ring_modulator.sv */
`timescale 1ns / 1ps

// Dual-oscillator ring modulator.
// Input channel: in_valid/in_stall carry a channel number per transaction; each
// transaction asks for the next output sample of that channel.
// Result channel: out_valid/out_stall carry out_sample (signed Q1.15) and
// out_bad_channel, exactly one result per input transaction, in order.
// Config: cfg_we writes cfg_wdata into register cfg_index (0 step A, 1 step B,
// 2 gain A, 3 gain B); write only while the block is idle.
// A valid channel steps through S_MA, S_MB and S_MP before its result is
// registered; a bad channel gives zero with the flag set in the next cycle.
// A new transaction is taken only after the last one is done, since the single
// shared multiplier is used three times per sample (gain A, gain B, final
// product) and the single sine table port is read once per oscillator.
// Reset (rst_n low, synchronous): config registers and all phases clear to zero,
// output queue empty.
// A stalled result holds; in_stall stays high until the result register is
// empty or being taken, so nothing is dropped.
module dual_sine_ring_modulator #(
  parameter int CHANNELS        = dsrm_pkg::CHANNELS_DEF,
  parameter int PHASE_BITS      = dsrm_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = dsrm_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dsrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dsrm_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dsrm_pkg::CHAN_W-1:0]         in_channel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dsrm_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_bad_channel
);

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROM_SIZE = 1 << SINE_TABLE_BITS;
  localparam logic [3:0] NUM_CH = 4'(CHANNELS);

  typedef enum logic [1:0] {S_IDLE, S_MA, S_MB, S_MP} state_t;

  state_t state_r;

  logic [dsrm_pkg::CFG_W-1:0] step_a_r;
  logic [dsrm_pkg::CFG_W-1:0] step_b_r;
  logic signed [15:0]         gain_a_r;
  logic signed [15:0]         gain_b_r;

  logic [PHASE_BITS-1:0] phase_a_r [CHANNELS];
  logic [PHASE_BITS-1:0] phase_b_r [CHANNELS];
  logic [PHASE_BITS-1:0] pa_r;
  logic [PHASE_BITS-1:0] pb_r;
  logic [CH_W-1:0]       ch_r;

  logic signed [15:0] sin_r;
  logic signed [31:0] va_r;
  logic signed [31:0] vb_r;

  logic                out_valid_r;
  logic signed [15:0]  out_sample_r;
  logic                out_bad_r;

  logic [14:0] rom_w [ROM_SIZE];

  for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
    assign rom_w[k] = dsrm_pkg::rom_entry(k, SINE_TABLE_BITS);
  end

  logic            in_acc;
  logic            in_bad;
  logic [CH_W-1:0] in_idx;

  assign in_idx = in_channel[CH_W-1:0];
  assign in_bad = {1'b0, in_channel} >= NUM_CH;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc = in_valid && !in_stall;

  // shared sine lookup
  logic [PHASE_BITS-1:0]      lk_phase;
  logic [1:0]                 lk_quad;
  logic [SINE_TABLE_BITS-1:0] lk_idx;
  logic [14:0]                lk_mag;
  logic signed [15:0]         lk_sine;

  always_comb begin
    lk_phase = (state_r == S_IDLE) ? phase_a_r[in_idx] : phase_b_r[ch_r];
    lk_quad  = lk_phase[PHASE_BITS-1 -: 2];
    lk_idx   = lk_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    if (lk_quad[0]) begin
      lk_idx = ~lk_idx;
    end
    lk_mag  = rom_w[lk_idx];
    lk_sine = lk_quad[1] ? -$signed({1'b0, lk_mag}) : $signed({1'b0, lk_mag});
  end

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;

  always_comb begin
    case (state_r)
      S_MA: begin
        mul_a = 32'(gain_a_r);
        mul_b = 32'(sin_r);
      end
      S_MB: begin
        mul_a = 32'(gain_b_r);
        mul_b = 32'(sin_r);
      end
      S_MP: begin
        mul_a = va_r;
        mul_b = vb_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_a_r    <= '0;
      step_b_r    <= '0;
      gain_a_r    <= '0;
      gain_b_r    <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        phase_a_r[c] <= '0;
        phase_b_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (dsrm_pkg::cfg_reg_t'(cfg_index))
          dsrm_pkg::REG_STEP_A: step_a_r <= cfg_wdata;
          dsrm_pkg::REG_STEP_B: step_b_r <= cfg_wdata;
          dsrm_pkg::REG_GAIN_A: gain_a_r <= cfg_wdata[15:0];
          dsrm_pkg::REG_GAIN_B: gain_b_r <= cfg_wdata[15:0];
        endcase
      end

      if (out_valid_r && !out_stall && !(in_acc && in_bad)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_bad) begin
              out_valid_r  <= 1'b1;
              out_sample_r <= '0;
              out_bad_r    <= 1'b1;
            end else begin
              ch_r    <= in_idx;
              pa_r    <= lk_phase;
              sin_r   <= lk_sine;
              state_r <= S_MA;
            end
          end
        end
        S_MA: begin
          va_r    <= mul_p[31:0];
          pb_r    <= lk_phase;
          sin_r   <= lk_sine;
          state_r <= S_MB;
        end
        S_MB: begin
          vb_r    <= mul_p[31:0];
          state_r <= S_MP;
        end
        S_MP: begin
          out_valid_r     <= 1'b1;
          out_sample_r    <= mul_p[60:45];
          out_bad_r       <= 1'b0;
          phase_a_r[ch_r] <= pa_r + step_a_r[PHASE_BITS-1:0];
          phase_b_r[ch_r] <= pb_r + step_b_r[PHASE_BITS-1:0];
          state_r         <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_bad_channel = out_bad_r;

endmodule

/* hdl/dsrm_checker.sv */
`timescale 1ns / 1ps

module dsrm_checker #(
  parameter int CHANNELS = dsrm_pkg::CHANNELS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [dsrm_pkg::CHAN_W-1:0]         in_channel,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [dsrm_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                out_bad_channel
);

  localparam logic [3:0] NUM_CH = 4'(CHANNELS);

  logic acc_bad;
  logic acc_good;

  assign acc_bad  = in_valid && !in_stall && ({1'b0, in_channel} >= NUM_CH);
  assign acc_good = in_valid && !in_stall && ({1'b0, in_channel} < NUM_CH);

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_channel |-> out_sample == '0)
    else $error("bad-channel result with nonzero sample");

  a_bad_next: assert property (@(posedge clk) disable iff (!rst_n)
    acc_bad |=> out_valid && out_bad_channel)
    else $error("bad channel not flagged on next cycle");

  a_good_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_good |=> in_stall)
    else $error("input taken while a sample is in progress");

  a_good_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc_good |-> ##4 (out_valid && !out_bad_channel))
    else $error("sample result missing four cycles after transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample))
    else $error("stalled result changed");

endmodule

bind dual_sine_ring_modulator dsrm_checker #(
  .CHANNELS(CHANNELS)
) u_dsrm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_channel     (in_channel),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample     (out_sample),
  .out_bad_channel(out_bad_channel)
);
